// File: rtl/xyz_to_rgb_constrain_normalize_macros.svh
// Assertion macros used by the checker file of the color conversion block.
`ifndef XYZ_TO_RGB_CONSTRAIN_NORMALIZE_MACROS_SVH
`define XYZ_TO_RGB_CONSTRAIN_NORMALIZE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define XTR_ASSERT(label, clk, rstn, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define XTR_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/xtr_pkg.sv
// Shared widths, types and conversion coefficients of the XYZ to RGB block.
`default_nettype none

package xtr_pkg;

  localparam int IN_W   = 16;
  localparam int OUT_W  = 16;
  localparam int COEF_W = 19;
  localparam int PROD_W = IN_W + COEF_W;
  localparam int CH_W   = PROD_W + 2;
  // Shifted channels are non-negative and stay below 2^34.
  localparam int SH_W   = 35;

  localparam int OUT_FRAC_BITS_DEF = 15;

  typedef logic signed [IN_W-1:0]   tri_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [CH_W-1:0]   ch_t;
  typedef logic        [SH_W-1:0]   sh_t;
  typedef logic        [OUT_W-1:0]  pix_t;

  // XYZ to RGB matrix for equal-energy white,
  // signed with 16 fraction bits, rows in R, G, B order.
  localparam coef_t CONV_COEF [3][3] = '{
    '{ 19'sd149936, -19'sd54616, -19'sd29784 },
    '{ -19'sd33532,  19'sd93242,   19'sd5826 },
    '{    19'sd375,  -19'sd1042,  19'sd66204 }
  };

endpackage

`default_nettype wire

// File: rtl/xtr_matmul.sv
// Two-stage 3x3 matrix multiply: nine products, then the three row sums.
`default_nettype none

module xtr_matmul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  xtr_pkg::tri_t xyz_i [3],
  output logic          valid_o,
  input  logic          ready_i,
  output xtr_pkg::ch_t  ch_o [3]
);

  logic          prod_v_q;
  logic          sum_v_q;
  logic          prod_rdy;
  logic          sum_rdy;
  xtr_pkg::prod_t prod_q [3][3];
  xtr_pkg::ch_t   sum_q [3];

  assign sum_rdy  = !sum_v_q || ready_i;
  assign prod_rdy = !prod_v_q || sum_rdy;
  assign ready_o  = prod_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      sum_v_q  <= 1'b0;
    end else begin
      if (prod_rdy) begin
        prod_v_q <= valid_i;
      end
      if (sum_rdy) begin
        sum_v_q <= prod_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_rdy) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= xtr_pkg::PROD_W'(xyz_i[j]) *
                          xtr_pkg::PROD_W'(xtr_pkg::CONV_COEF[i][j]);
        end
      end
    end
    if (sum_rdy) begin
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= xtr_pkg::CH_W'(prod_q[i][0]) + xtr_pkg::CH_W'(prod_q[i][1]) +
                    xtr_pkg::CH_W'(prod_q[i][2]);
      end
    end
  end

  assign valid_o = sum_v_q;
  assign ch_o    = sum_q;

endmodule

`default_nettype wire

// File: rtl/xtr_constrain.sv
// Three-stage gamut constraint: find the lowest channel, shift all, find the top.
`default_nettype none

module xtr_constrain (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  xtr_pkg::ch_t ch_i [3],
  output logic         valid_o,
  input  logic         ready_i,
  output xtr_pkg::sh_t chan_o [3],
  output xtr_pkg::sh_t top_o
);

  logic         low_v_q;
  logic         shift_v_q;
  logic         top_v_q;
  logic         low_rdy;
  logic         shift_rdy;
  logic         top_rdy;
  xtr_pkg::ch_t low_d;
  xtr_pkg::ch_t low_q;
  xtr_pkg::ch_t ch_q [3];
  xtr_pkg::sh_t shift_q [3];
  xtr_pkg::sh_t top_d;
  xtr_pkg::sh_t chan_q [3];
  xtr_pkg::sh_t top_q;

  assign top_rdy   = !top_v_q || ready_i;
  assign shift_rdy = !shift_v_q || top_rdy;
  assign low_rdy   = !low_v_q || shift_rdy;
  assign ready_o   = low_rdy;

  // The lowest channel, clamped at zero, is the amount of white to add.
  always_comb begin
    low_d = '0;
    for (int i = 0; i < 3; i++) begin
      if (ch_i[i] < low_d) begin
        low_d = ch_i[i];
      end
    end
  end

  always_comb begin
    top_d = shift_q[0];
    for (int i = 1; i < 3; i++) begin
      if (shift_q[i] > top_d) begin
        top_d = shift_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_v_q   <= 1'b0;
      shift_v_q <= 1'b0;
      top_v_q   <= 1'b0;
    end else begin
      if (low_rdy) begin
        low_v_q <= valid_i;
      end
      if (shift_rdy) begin
        shift_v_q <= low_v_q;
      end
      if (top_rdy) begin
        top_v_q <= shift_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (low_rdy) begin
      low_q <= low_d;
      ch_q  <= ch_i;
    end
    if (shift_rdy) begin
      for (int i = 0; i < 3; i++) begin
        shift_q[i] <= xtr_pkg::SH_W'(ch_q[i] - low_q);
      end
    end
    if (top_rdy) begin
      chan_q <= shift_q;
      top_q  <= top_d;
    end
  end

  assign valid_o = top_v_q;
  assign chan_o  = chan_q;
  assign top_o   = top_q;

endmodule

`default_nettype wire

// File: rtl/xtr_div.sv
// Pipelined restoring divider, one quotient bit per stage, three channel lanes.
`default_nettype none

module xtr_div #(
  parameter int OUT_FRAC_BITS = xtr_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  xtr_pkg::sh_t           chan_i [3],
  input  xtr_pkg::sh_t           top_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [OUT_FRAC_BITS:0] quo_o [3],
  output logic                   zero_o
);

  localparam int QW = OUT_FRAC_BITS + 1;
  localparam int NS = QW;
  localparam int NW = xtr_pkg::SH_W + QW;

  // Stage 0 forms the rounded dividend; stages 1..NS each retire one bit.
  logic         v_q    [NS+1];
  logic         rdy    [NS+2];
  xtr_pkg::sh_t rem_q  [NS+1][3];
  logic [QW-1:0] nq_q  [NS+1][3];
  xtr_pkg::sh_t div_q  [NS+1];
  logic         zero_q [NS+1];

  logic [NW-1:0] num_d [3];

  assign rdy[NS+1] = ready_i;
  assign ready_o   = rdy[0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_d[i] = (NW'(chan_i[i]) << OUT_FRAC_BITS) + NW'(top_i >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_q[0] <= valid_i;
    end
  end

  // The high part of the dividend is below the divisor, so it seeds the remainder.
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[0][i] <= num_d[i][NW-1:QW];
        nq_q[0][i]  <= num_d[i][QW-1:0];
      end
      div_q[0]  <= top_i;
      zero_q[0] <= (top_i == '0);
    end
  end

  for (genvar k = 0; k <= NS; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  for (genvar k = 1; k <= NS; k++) begin : g_step
    logic [xtr_pkg::SH_W:0] ext_d  [3];
    logic [xtr_pkg::SH_W:0] diff_d [3];
    xtr_pkg::sh_t           rem_d  [3];
    logic [QW-1:0]          nq_d   [3];

    // Dividend bits leave nq at the top while quotient bits enter at the bottom.
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ext_d[i]  = {rem_q[k-1][i], nq_q[k-1][i][QW-1]};
        diff_d[i] = ext_d[i] - {1'b0, div_q[k-1]};
        if (!diff_d[i][xtr_pkg::SH_W]) begin
          rem_d[i] = diff_d[i][xtr_pkg::SH_W-1:0];
          nq_d[i]  = {nq_q[k-1][i][QW-2:0], 1'b1};
        end else begin
          rem_d[i] = ext_d[i][xtr_pkg::SH_W-1:0];
          nq_d[i]  = {nq_q[k-1][i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        rem_q[k]  <= rem_d;
        nq_q[k]   <= nq_d;
        div_q[k]  <= div_q[k-1];
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  assign valid_o = v_q[NS];
  assign quo_o   = nq_q[NS];
  assign zero_o  = zero_q[NS];

endmodule

`default_nettype wire

// File: rtl/xyz_to_rgb_constrain_normalize.sv
// Depth: OUT_FRAC_BITS + 8 register stages. Throughput: one XYZ triple per clock;
// every stage holds under backpressure. The divider contributes OUT_FRAC_BITS + 2
// stages: one that forms the dividend, then one per quotient bit.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; no result is lost
// or repeated under stalls, and a stage with a bubble still takes a new item.
`default_nettype none

module xyz_to_rgb_constrain_normalize #(
  parameter int OUT_FRAC_BITS = xtr_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // tristim_x [15:0], tristim_y [31:16], tristim_z [47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // red_out [15:0], green_out [31:16], blue_out [47:32]
);

  localparam int QW  = OUT_FRAC_BITS + 1;
  localparam int QXW = (QW > xtr_pkg::OUT_W) ? QW : xtr_pkg::OUT_W;

  xtr_pkg::tri_t xyz    [3];
  xtr_pkg::ch_t  ch     [3];
  xtr_pkg::sh_t  chan   [3];
  xtr_pkg::sh_t  top;
  logic [QW-1:0] quo    [3];
  logic          mm_valid;
  logic          mm_ready;
  logic          cs_valid;
  logic          cs_ready;
  logic          dv_valid;
  logic          dv_zero;
  logic          out_rdy;
  logic          out_v_q;
  xtr_pkg::pix_t pix_d  [3];
  xtr_pkg::pix_t pix_q  [3];
  logic [QXW-1:0] quo_ext [3];

  assign xyz[0] = s_axis_tdata[15:0];
  assign xyz[1] = s_axis_tdata[31:16];
  assign xyz[2] = s_axis_tdata[47:32];

  xtr_matmul u_matmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .xyz_i   (xyz),
    .valid_o (mm_valid),
    .ready_i (mm_ready),
    .ch_o    (ch)
  );

  xtr_constrain u_constrain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mm_valid),
    .ready_o (mm_ready),
    .ch_i    (ch),
    .valid_o (cs_valid),
    .ready_i (cs_ready),
    .chan_o  (chan),
    .top_o   (top)
  );

  xtr_div #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cs_valid),
    .ready_o (cs_ready),
    .chan_i  (chan),
    .top_i   (top),
    .valid_o (dv_valid),
    .ready_i (out_rdy),
    .quo_o   (quo),
    .zero_o  (dv_zero)
  );

  assign out_rdy = !out_v_q || m_axis_tready;

  // A zero divisor means every channel is zero; the quotient is forced to match.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quo_ext[i] = QXW'(quo[i]);
      if (dv_zero) begin
        pix_d[i] = '0;
      end else if (quo_ext[i] > QXW'({xtr_pkg::OUT_W{1'b1}})) begin
        pix_d[i] = '1;
      end else begin
        pix_d[i] = quo_ext[i][xtr_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      pix_q <= pix_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {pix_q[2], pix_q[1], pix_q[0]};

endmodule

`default_nettype wire

// File: rtl/xtr_checker.sv
// Port-level checker for the XYZ to RGB block, bound to the top level.
`default_nettype none

`include "xyz_to_rgb_constrain_normalize_macros.svh"

module xtr_checker #(
  parameter int OUT_FRAC_BITS = xtr_pkg::OUT_FRAC_BITS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  localparam logic [15:0] FULL = (OUT_FRAC_BITS > 15) ? 16'hFFFF : 16'(1 << OUT_FRAC_BITS);

  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;

  assign red   = m_axis_tdata[15:0];
  assign green = m_axis_tdata[31:16];
  assign blue  = m_axis_tdata[47:32];

  `XTR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output transfer changed")
  `XTR_ASSERT(a_idle_ready, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "input stalled with an empty output")
  `XTR_ASSERT(a_has_full, clk_i, rst_ni, m_axis_tvalid, red == FULL || green == FULL || blue == FULL || (red == 16'd0 && green == 16'd0 && blue == 16'd0), "largest channel not at full scale")
  `XTR_ASSERT(a_in_range, clk_i, rst_ni, m_axis_tvalid, red <= FULL && green <= FULL && blue <= FULL, "channel above full scale")

endmodule

bind xyz_to_rgb_constrain_normalize xtr_checker #(
  .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_checker (.*);

`default_nettype wire

// File: sim/tb_xyz_to_rgb_constrain_normalize.sv
// Self-checking testbench for the XYZ to RGB constrain and normalize pipeline.
`timescale 1ns / 100ps

module tb_xyz_to_rgb_constrain_normalize;

  typedef xtr_pkg::tri_t tri_t;
  typedef xtr_pkg::pix_t pix_t;

  localparam int NORM_FRAC_BITS = 15;
  localparam int PIPE_LATENCY   = NORM_FRAC_BITS + 8;
  localparam int RANDOM_PER_PHASE = 550;

  // Coefficients with 16 fraction bits, rows R, G, B; every row sums to about 1.0.
  localparam longint XYZ2RGB [3][3] = '{
    '{ 149936, -54616, -29784 },
    '{ -33532,  93242,   5826 },
    '{    375,  -1042,  66204 }
  };

  typedef struct packed {
    pix_t blue;
    pix_t green;
    pix_t red;
  } rgb_t;

  class rgb_scoreboard;
    rgb_t expected_rgb_q[$];
    int   errors;
    int   n_in;
    int   n_out;
    int   n_lifted;
    int   n_black;

    function new();
      errors   = 0;
      n_in     = 0;
      n_out    = 0;
      n_lifted = 0;
      n_black  = 0;
    endfunction

    function rgb_t convert_xyz(tri_t x, tri_t y, tri_t z);
      longint          xyz [3];
      longint          ch [3];
      longint          acc;
      longint          low;
      longint          top;
      longint unsigned num;
      longint unsigned q;
      pix_t            o [3];
      rgb_t            res;
      xyz[0] = x;
      xyz[1] = y;
      xyz[2] = z;
      low = 0;
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += XYZ2RGB[i][j] * xyz[j];
        ch[i] = acc;
        if (acc < low) low = acc;
      end
      if (low < 0) n_lifted++;
      // Add just enough white that no channel stays negative.
      for (int i = 0; i < 3; i++) ch[i] -= low;
      top = ch[0];
      if (ch[1] > top) top = ch[1];
      if (ch[2] > top) top = ch[2];
      if (top == 0) n_black++;
      for (int i = 0; i < 3; i++) begin
        q = 0;
        if (top > 0) begin
          num = longint'(ch[i]) << NORM_FRAC_BITS;
          q = (num + (longint'(top) >> 1)) / longint'(top);
        end
        if (q > 64'hFFFF) q = 64'hFFFF;
        o[i] = q[15:0];
      end
      res.red   = o[0];
      res.green = o[1];
      res.blue  = o[2];
      return res;
    endfunction

    function void note_input(logic [47:0] d);
      n_in++;
      expected_rgb_q.push_back(convert_xyz(d[15:0], d[31:16], d[47:32]));
    endfunction

    task report(string msg);
      if (errors < 30) $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [47:0] d);
      rgb_t exp_rgb;
      rgb_t got;
      got = d;
      n_out++;
      if (expected_rgb_q.size() == 0) begin
        report($sformatf("unexpected result %h", d));
      end else begin
        exp_rgb = expected_rgb_q.pop_front();
        if (got.red !== exp_rgb.red)
          report($sformatf("red %0d, want %0d", got.red, exp_rgb.red));
        if (got.green !== exp_rgb.green)
          report($sformatf("green %0d, want %0d", got.green, exp_rgb.green));
        if (got.blue !== exp_rgb.blue)
          report($sformatf("blue %0d, want %0d", got.blue, exp_rgb.blue));
      end
    endtask
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  rgb_scoreboard sb = new();

  xyz_to_rgb_constrain_normalize uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Both transfers are observed on the values settled before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  task automatic send_triple(tri_t x, tri_t y, tri_t z);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {z, y, x};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_rgb_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 5) @(posedge clk_i);
  endtask

  initial begin
    tri_t x;
    tri_t y;
    tri_t z;
    int   v;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      if (phase == 0) begin
        send_triple(16'sd0, 16'sd0, 16'sd0);
        send_triple(16'sd32767, 16'sd32767, 16'sd32767);
        send_triple(-16'sd32768, -16'sd32768, -16'sd32768);
        send_triple(16'sd32767, 16'sd0, 16'sd0);
        send_triple(16'sd0, 16'sd32767, 16'sd0);
        send_triple(16'sd0, 16'sd0, 16'sd32767);
        send_triple(-16'sd32768, 16'sd0, 16'sd0);
        send_triple(16'sd0, -16'sd32768, 16'sd0);
        send_triple(16'sd0, 16'sd0, -16'sd32768);
        send_triple(16'sd32767, -16'sd32768, 16'sd32767);
        send_triple(-16'sd32768, 16'sd32767, -16'sd32768);
        send_triple(16'sd32767, -16'sd32768, -16'sd32768);
        send_triple(-16'sd32768, 16'sd32767, 16'sd32767);
        send_triple(16'sd32767, 16'sd32767, -16'sd32768);
        send_triple(-16'sd32768, -16'sd32768, 16'sd32767);
        send_triple(16'sd1, 16'sd0, 16'sd0);
        send_triple(-16'sd1, 16'sd0, 16'sd0);
        send_triple(16'sd0, 16'sd0, 16'sd1);
        // Equal-energy white gives nearly equal channels.
        send_triple(16'sd8192, 16'sd8192, 16'sd8192);
        send_triple(16'sd1, 16'sd1, 16'sd1);
        send_triple(-16'sd1, -16'sd1, -16'sd1);
        send_triple(16'sh5555, -16'sh5556, 16'sh5555);
        send_triple(-16'sh5556, 16'sh5555, -16'sh5556);
      end

      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        case ($urandom_range(9))
          6, 7: begin
            // Tiny values put small divisors through the normalizer.
            x = tri_t'($urandom_range(32)) - 16'sd16;
            y = tri_t'($urandom_range(32)) - 16'sd16;
            z = tri_t'($urandom_range(32)) - 16'sd16;
          end
          8: begin
            v = $urandom;
            x = tri_t'(v);
            y = tri_t'(v) + tri_t'($urandom_range(4)) - 16'sd2;
            z = tri_t'(v) + tri_t'($urandom_range(4)) - 16'sd2;
          end
          9: begin
            x = $urandom_range(1) ? 16'sd32767 : -16'sd32768;
            y = $urandom_range(1) ? tri_t'($urandom) : 16'sd0;
            z = $urandom_range(1) ? -16'sd32768 : 16'sd32767;
          end
          default: begin
            x = tri_t'($urandom);
            y = tri_t'($urandom);
            z = tri_t'($urandom);
          end
        endcase
        send_triple(x, y, z);
      end

      // Hold the sender off until the pipeline has emptied.
      drain_results();
    end

    if (sb.expected_rgb_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_rgb_q.size()));

    $display("Summary: %0d triples sent, %0d results checked, %0d lifted from negative, %0d black.",
             sb.n_in, sb.n_out, sb.n_lifted, sb.n_black);
    $display("Summary: stalls on sender and receiver in turn, then a full-rate stretch.");
    if (sb.errors == 0) begin
      $display("tb_xyz_to_rgb_constrain_normalize OK");
    end else begin
      $display("tb_xyz_to_rgb_constrain_normalize NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout: pipeline stopped delivering results.");
    $display("tb_xyz_to_rgb_constrain_normalize NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/xtr_pkg.sv
rtl/xtr_matmul.sv
rtl/xtr_constrain.sv
rtl/xtr_div.sv
rtl/xyz_to_rgb_constrain_normalize.sv
rtl/xtr_checker.sv
sim/tb_xyz_to_rgb_constrain_normalize.sv
